/* rtl/sacc_pkg.sv */
// ----------------------------------------------------------------------------
// sacc_pkg
// Shared types and constants for the set-associative block cache controller:
// field widths, opcodes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package sacc_pkg;

  // Field widths of the access and result words
  localparam int ID_W   = 32;
  localparam int OFF_W  = 10;
  localparam int SIZE_W = 32;
  localparam int SET_W  = 4;
  localparam int WAY_W  = 2;
  localparam int LEN_W  = 10;
  localparam int AGE_W  = 8;

  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

  // Set modulo unit: block id bits folded per cycle
  localparam int MOD_BITS   = 8;
  localparam int MOD_CHUNKS = ID_W / MOD_BITS;
  localparam int MOD_CNT_W  = $clog2(MOD_CHUNKS + 1);

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_FLUSH     = 2'd2,
    OP_FLUSH_ALL = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_RD,
    S_EVAL,
    S_EMIT,
    S_FA_START,
    S_FA_RD,
    S_FA_SCAN,
    S_FA_NONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic rd_set;
    logic eval;
    logic commit;
    logic walk_start;
    logic walk_next_way;
    logic walk_next_set;
    logic fa_emit;
    logic emit_none;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mod_done;
    logic count_zero;
    logic count_one;
    logic entry_dirty;
    logic way_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/set_assoc_block_cache_ctrl.sv */
// ----------------------------------------------------------------------------
// set_assoc_block_cache_ctrl
// Directory and LRU-by-age replacement engine of a write-back,
// set-associative block cache.
// ----------------------------------------------------------------------------
// Each input word is one access: read, write, flush one block or flush all.
// The set is block_id modulo SETS. A read or write raises the ages of the
// valid ways in its set (saturating at 255), zeroes the age of a hit way, and
// on a miss picks the first invalid way or else the oldest (ties to the higher
// way), reports a dirty victim for writeback and requests a fill. Writes mark
// the way dirty. An out-of-range offset returns one word with offset_error
// set and changes nothing. Flush-one clears the dirty bit of a matching way
// and reports it for writeback. Flush-all returns one word per dirty valid
// way in set then way order, the final one marked by last, or a single word
// with only last set when nothing is dirty. Read, write and flush-one pass
// from acceptance through the set modulo unit (8 id bits per cycle), a
// directory RAM read, an evaluation step, a commit that waits for a free
// output register and the return to idle before the next ready. Flush-all
// reads one RAM row per set and scans its ways one by one, waiting for a
// free output register at each dirty way, and stops right after the last
// dirty way, which a running dirty counter tells ahead of time. The output
// register lets a new word be accepted while the previous result still
// waits. Valid and dirty flags reset to zero; tags and ages are held in RAM
// and read only behind a valid flag, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module set_assoc_block_cache_ctrl import sacc_pkg::*; #(
  parameter int SETS        = 16,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // access channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [ID_W-1:0]   block_id_i,
  input  logic [OFF_W-1:0]  offset_i,
  input  logic [SIZE_W-1:0] size_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [SET_W-1:0]  set_index_o,
  output logic [WAY_W-1:0]  way_o,
  output logic [LEN_W-1:0]  length_o,
  output logic              offset_error_o,
  output logic              writeback_valid_o,
  output logic [ID_W-1:0]   writeback_block_o,
  output logic              fill_valid_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  // sequence each access and the flush-all walk
  sacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold the directory, evaluate hits and victims, drive the result word
  sacc_dpath #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (opcode_i),
    .block_id_i        (block_id_i),
    .offset_i          (offset_i),
    .size_i            (size_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .hit_o             (hit_o),
    .set_index_o       (set_index_o),
    .way_o             (way_o),
    .length_o          (length_o),
    .offset_error_o    (offset_error_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_block_o (writeback_block_o),
    .fill_valid_o      (fill_valid_o),
    .last_o            (last_o)
  );

endmodule

/* rtl/sacc_ram.sv */
// ----------------------------------------------------------------------------
// sacc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sacc_setmod.sv */
// ----------------------------------------------------------------------------
// sacc_setmod
// Multi-cycle block id modulo SETS: folds MOD_BITS bits of the id per cycle
// by shift and conditional subtract.
// ----------------------------------------------------------------------------
module sacc_setmod import sacc_pkg::*; #(
  parameter int SETS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ID_W-1:0]  id_i,
  output logic [SET_W-1:0] set_o,
  output logic             done_o
);

  logic [ID_W-1:0]      sh_q, sh_d;
  logic [SET_W-1:0]     r_q, r_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [SET_W-1:0]     step_r;

  // one remainder step per id bit, MSB first
  always_comb begin
    logic [SET_W:0] r;
    r = {1'b0, r_q};
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[SET_W-1:0], sh_q[ID_W-1-i]};
      if (r >= (SET_W+1)'(SETS)) begin
        r = r - (SET_W+1)'(SETS);
      end
    end
    step_r = r[SET_W-1:0];
  end

  always_comb begin
    sh_d  = sh_q;
    r_d   = r_q;
    cnt_d = cnt_q;
    if (start_i) begin
      sh_d  = id_i;
      r_d   = '0;
      cnt_d = MOD_CNT_W'(MOD_CHUNKS);
    end else if (cnt_q != '0) begin
      sh_d  = sh_q << MOD_BITS;
      r_d   = step_r;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q  <= r_d;
  end

  assign set_o  = r_q;
  assign done_o = (cnt_q == '0);

endmodule

/* rtl/sacc_dpath.sv */
// ----------------------------------------------------------------------------
// sacc_dpath
// Directory datapath: input capture, set modulo, tag/age RAM, valid and dirty
// flags, hit/victim evaluation, dirty counter, flush walker, output register.
// ----------------------------------------------------------------------------
module sacc_dpath import sacc_pkg::*; #(
  parameter int SETS        = 16,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [ID_W-1:0]   block_id_i,
  input  logic [OFF_W-1:0]  offset_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              hit_o,
  output logic [SET_W-1:0]  set_index_o,
  output logic [WAY_W-1:0]  way_o,
  output logic [LEN_W-1:0]  length_o,
  output logic              offset_error_o,
  output logic              writeback_valid_o,
  output logic [ID_W-1:0]   writeback_block_o,
  output logic              fill_valid_o,
  output logic              last_o
);

  localparam int SA_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WA_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRIES = SETS * WAYS;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int TAGS_W  = WAYS * ID_W;
  localparam int ROW_W   = WAYS * (ID_W + AGE_W);
  localparam int BB_W    = OFF_W + 1;

  typedef logic [WAYS-1:0][ID_W-1:0]  tag_row_t;
  typedef logic [WAYS-1:0][AGE_W-1:0] age_row_t;

  // captured access
  op_e               op_q;
  logic [ID_W-1:0]   id_q;
  logic [OFF_W-1:0]  off_q;
  logic [SIZE_W-1:0] size_q;

  logic [SET_W-1:0]  set_w;
  logic [SA_W-1:0]   set_idx;
  logic              mod_done;

  logic [SETS-1:0][WAYS-1:0] valid_q, dirty_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [SA_W-1:0]           walk_s_q;
  logic [WA_W-1:0]           walk_w_q;

  logic             ram_we, ram_re;
  logic [SA_W-1:0]  ram_raddr;
  logic [ROW_W-1:0] rd_row;
  tag_row_t         rd_tags;
  age_row_t         rd_ages;

  // evaluation results
  logic             dec_err_q, dec_hit_q, dec_wb_q, dec_fill_q;
  logic [WA_W-1:0]  dec_way_q;
  logic [LEN_W-1:0] dec_len_q;
  logic [ID_W-1:0]  dec_wbb_q;
  tag_row_t         dec_tags_q;
  age_row_t         dec_ages_q;

  logic             ev_err, ev_hit, ev_wb, ev_fill;
  logic [WA_W-1:0]  ev_way;
  logic [LEN_W-1:0] ev_len;
  logic [ID_W-1:0]  ev_wbb;
  tag_row_t         ev_tags;
  age_row_t         ev_ages;

  logic out_valid_q, out_free, out_load;

  sacc_setmod #(
    .SETS (SETS)
  ) u_setmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept),
    .id_i    (block_id_i),
    .set_o   (set_w),
    .done_o  (mod_done)
  );

  assign set_idx = set_w[SA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(opcode_i);
      id_q   <= block_id_i;
      off_q  <= offset_i;
      size_q <= size_i;
    end
  end

  // directory RAM: one row per set, ages above tags
  always_comb begin
    if (cmd_i.walk_start) begin
      ram_raddr = '0;
    end else if (cmd_i.walk_next_set) begin
      ram_raddr = SA_W'(walk_s_q + 1'b1);
    end else begin
      ram_raddr = set_idx;
    end
  end

  assign ram_re = cmd_i.rd_set | cmd_i.walk_start | cmd_i.walk_next_set;
  assign ram_we = cmd_i.commit && !dec_err_q && (op_q != OP_FLUSH);

  sacc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_idx),
    .wdata_i ({dec_ages_q, dec_tags_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_row)
  );

  assign rd_tags = rd_row[TAGS_W-1:0];
  assign rd_ages = rd_row[ROW_W-1:TAGS_W];

  // hit, victim and next row for the captured access
  always_comb begin
    logic [WAYS-1:0]  vrow, drow;
    logic             is_write, is_flush, bad, hit, inv_found;
    logic [BB_W-1:0]  avail;
    logic [WA_W-1:0]  hit_way, inv_way, old_way, victim;
    age_row_t         raised;

    vrow     = valid_q[set_idx];
    drow     = dirty_q[set_idx];
    is_write = (op_q == OP_WRITE);
    is_flush = (op_q == OP_FLUSH);

    if (is_write) begin
      bad = ({1'b0, off_q} >= BB_W'(BLOCK_BYTES));
    end else begin
      bad = !is_flush && ({1'b0, off_q} > BB_W'(BLOCK_BYTES));
    end
    avail = BB_W'(BLOCK_BYTES) - {1'b0, off_q};

    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && (rd_tags[w] == id_q)) begin
        hit     = 1'b1;
        hit_way = WA_W'(w);
      end
    end

    for (int w = 0; w < WAYS; w++) begin
      if (vrow[w] && (rd_ages[w] != AGE_MAX)) begin
        raised[w] = rd_ages[w] + 1'b1;
      end else begin
        raised[w] = rd_ages[w];
      end
    end

    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow[w]) begin
        inv_found = 1'b1;
        inv_way   = WA_W'(w);
      end
    end

    // oldest way, ties go to the higher way
    old_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (raised[old_way] <= raised[w]) begin
        old_way = WA_W'(w);
      end
    end
    victim = inv_found ? inv_way : old_way;

    ev_err  = bad;
    ev_hit  = 1'b0;
    ev_way  = '0;
    ev_len  = '0;
    ev_wb   = 1'b0;
    ev_wbb  = '0;
    ev_fill = 1'b0;
    ev_tags = rd_tags;
    ev_ages = raised;

    if (is_flush) begin
      ev_hit = hit;
      ev_way = hit_way;
      ev_wb  = hit && drow[hit_way];
      ev_wbb = (hit && drow[hit_way]) ? id_q : '0;
    end else if (!bad) begin
      ev_hit = hit;
      if (size_q < SIZE_W'(avail)) begin
        ev_len = size_q[LEN_W-1:0];
      end else begin
        ev_len = avail[LEN_W-1:0];
      end
      if (hit) begin
        ev_way          = hit_way;
        ev_ages[hit_way] = '0;
      end else begin
        ev_way          = victim;
        ev_wb           = vrow[victim] && drow[victim];
        ev_wbb          = (vrow[victim] && drow[victim]) ? rd_tags[victim] : '0;
        ev_fill         = 1'b1;
        ev_tags[victim] = id_q;
        ev_ages[victim] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      dec_err_q  <= ev_err;
      dec_hit_q  <= ev_hit;
      dec_way_q  <= ev_way;
      dec_len_q  <= ev_len;
      dec_wb_q   <= ev_wb;
      dec_wbb_q  <= ev_wbb;
      dec_fill_q <= ev_fill;
      dec_tags_q <= ev_tags;
      dec_ages_q <= ev_ages;
    end
  end

  // flag and counter update on commit
  logic commit_upd, old_d, old_vd, new_d, new_vd;

  always_comb begin
    old_d  = dirty_q[set_idx][dec_way_q];
    old_vd = valid_q[set_idx][dec_way_q] && old_d;
    if (op_q == OP_FLUSH) begin
      new_d  = dec_hit_q ? 1'b0 : old_d;
      new_vd = dec_hit_q ? 1'b0 : old_vd;
    end else begin
      new_d  = dec_hit_q ? (old_d || (op_q == OP_WRITE)) : (op_q == OP_WRITE);
      new_vd = new_d;
    end
  end

  assign commit_upd = cmd_i.commit && !dec_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      dirty_q  <= '0;
      cnt_q    <= '0;
      walk_s_q <= '0;
      walk_w_q <= '0;
    end else begin
      if (commit_upd) begin
        dirty_q[set_idx][dec_way_q] <= new_d;
        if (op_q != OP_FLUSH) begin
          valid_q[set_idx][dec_way_q] <= 1'b1;
        end
        if (new_vd && !old_vd) begin
          cnt_q <= cnt_q + 1'b1;
        end else if (!new_vd && old_vd) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (cmd_i.fa_emit) begin
        dirty_q[walk_s_q][walk_w_q] <= 1'b0;
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.walk_start) begin
        walk_s_q <= '0;
        walk_w_q <= '0;
      end else if (cmd_i.walk_next_set) begin
        walk_s_q <= SA_W'(walk_s_q + 1'b1);
        walk_w_q <= '0;
      end else if (cmd_i.walk_next_way) begin
        walk_w_q <= WA_W'(walk_w_q + 1'b1);
      end
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.commit | cmd_i.fa_emit | cmd_i.emit_none;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o             <= dec_hit_q;
      set_index_o       <= set_w;
      way_o             <= WAY_W'(dec_way_q);
      length_o          <= dec_len_q;
      offset_error_o    <= dec_err_q;
      writeback_valid_o <= dec_wb_q;
      writeback_block_o <= dec_wbb_q;
      fill_valid_o      <= dec_fill_q;
      last_o            <= 1'b1;
    end else if (cmd_i.fa_emit) begin
      hit_o             <= 1'b1;
      set_index_o       <= SET_W'(walk_s_q);
      way_o             <= WAY_W'(walk_w_q);
      length_o          <= '0;
      offset_error_o    <= 1'b0;
      writeback_valid_o <= 1'b1;
      writeback_block_o <= rd_tags[walk_w_q];
      fill_valid_o      <= 1'b0;
      last_o            <= (cnt_q == CNT_W'(1));
    end else if (cmd_i.emit_none) begin
      hit_o             <= 1'b0;
      set_index_o       <= '0;
      way_o             <= '0;
      length_o          <= '0;
      offset_error_o    <= 1'b0;
      writeback_valid_o <= 1'b0;
      writeback_block_o <= '0;
      fill_valid_o      <= 1'b0;
      last_o            <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.mod_done    = mod_done;
  assign sts_o.count_zero  = (cnt_q == '0);
  assign sts_o.count_one   = (cnt_q == CNT_W'(1));
  assign sts_o.entry_dirty = valid_q[walk_s_q][walk_w_q] && dirty_q[walk_s_q][walk_w_q];
  assign sts_o.way_last    = (walk_w_q == WA_W'(WAYS - 1));
  assign sts_o.out_free    = out_free;

endmodule

/* rtl/sacc_ctrl.sv */
// ----------------------------------------------------------------------------
// sacc_ctrl
// Controller state machine: sequences access evaluation and the flush-all
// walk, and issues datapath commands.
// ----------------------------------------------------------------------------
module sacc_ctrl import sacc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_e'(opcode_i) == OP_FLUSH_ALL) ? S_FA_START : S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) state_d = S_RD;
      end
      S_RD:   state_d = S_EVAL;
      S_EVAL: state_d = S_EMIT;
      S_EMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_FA_START: state_d = sts_i.count_zero ? S_FA_NONE : S_FA_RD;
      S_FA_RD:    state_d = S_FA_SCAN;
      S_FA_SCAN: begin
        if (sts_i.entry_dirty) begin
          if (sts_i.out_free) begin
            if (sts_i.count_one) begin
              state_d = S_IDLE;
            end else if (sts_i.way_last) begin
              state_d = S_FA_RD;
            end
          end
        end else if (sts_i.way_last) begin
          state_d = S_FA_RD;
        end
      end
      S_FA_NONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    logic adv;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    adv        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_MOD:      cmd_o.rd_set     = sts_i.mod_done;
      S_RD:       ;
      S_EVAL:     cmd_o.eval       = 1'b1;
      S_EMIT:     cmd_o.commit     = sts_i.out_free;
      S_FA_START: cmd_o.walk_start = !sts_i.count_zero;
      S_FA_RD:    ;
      S_FA_SCAN: begin
        // skip clean ways; stop after the last dirty one
        adv = !sts_i.entry_dirty || (sts_i.out_free && !sts_i.count_one);
        cmd_o.fa_emit       = sts_i.entry_dirty && sts_i.out_free;
        cmd_o.walk_next_set = adv && sts_i.way_last;
        cmd_o.walk_next_way = adv && !sts_i.way_last;
      end
      S_FA_NONE:  cmd_o.emit_none  = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* tb/sv/cache_sb_pkg.sv */
// ----------------------------------------------------------------------------
// cache_sb_pkg
// Scoreboard for the block cache controller. It keeps its own copy of the
// directory (valid, dirty, tag and age per entry), predicts the result words
// of every accepted access and checks returned words in order.
// ----------------------------------------------------------------------------
package cache_sb_pkg;
  import sacc_pkg::*;

  localparam int CACHE_SETS        = 16;
  localparam int CACHE_WAYS        = 4;
  localparam int CACHE_BLOCK_BYTES = 512;
  localparam int ENTRY_CNT         = CACHE_SETS * CACHE_WAYS;

  typedef struct packed {
    logic             hit;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way;
    logic [LEN_W-1:0] length;
    logic             offset_error;
    logic             writeback_valid;
    logic [ID_W-1:0]  writeback_block;
    logic             fill_valid;
    logic             last;
  } result_word_t;

  class dir_scoreboard;
    logic             valid_q [ENTRY_CNT];
    logic             dirty_q [ENTRY_CNT];
    logic [ID_W-1:0]  tag_q   [ENTRY_CNT];
    logic [AGE_W-1:0] age_q   [ENTRY_CNT];
    result_word_t     expected_words[$];
    int               mismatches;

    function new();
      foreach (valid_q[e]) begin
        valid_q[e] = 1'b0;
        dirty_q[e] = 1'b0;
        tag_q[e]   = '0;
        age_q[e]   = '0;
      end
      mismatches = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Advance the directory by one access and queue the words it causes
    function void note_access(op_e op, logic [ID_W-1:0] id, logic [OFF_W-1:0] off,
                              logic [SIZE_W-1:0] size);
      int           set_no;
      int           base;
      int           victim;
      int           n_dirty;
      int           k;
      int           e;
      bit           found;
      bit           bad;
      logic [31:0]  avail;
      result_word_t w;

      set_no      = int'(id % CACHE_SETS);
      base        = set_no * CACHE_WAYS;
      w           = '0;
      w.set_index = SET_W'(set_no);
      w.last      = 1'b1;

      case (op)
        OP_FLUSH_ALL: begin
          n_dirty = 0;
          for (e = 0; e < ENTRY_CNT; e++) begin
            if (valid_q[e] && dirty_q[e]) n_dirty++;
          end
          if (n_dirty == 0) begin
            w.set_index = '0;
            expected_words.push_back(w);
            return;
          end
          k = 0;
          for (e = 0; e < ENTRY_CNT; e++) begin
            if (valid_q[e] && dirty_q[e]) begin
              k++;
              w                 = '0;
              w.hit             = 1'b1;
              w.set_index       = SET_W'(e / CACHE_WAYS);
              w.way             = WAY_W'(e % CACHE_WAYS);
              w.writeback_valid = 1'b1;
              w.writeback_block = tag_q[e];
              w.last            = (k == n_dirty);
              dirty_q[e]        = 1'b0;
              expected_words.push_back(w);
            end
          end
        end

        OP_FLUSH: begin
          for (k = 0; k < CACHE_WAYS; k++) begin
            e = base + k;
            if (valid_q[e] && tag_q[e] == id) begin
              w.hit             = 1'b1;
              w.way             = WAY_W'(k);
              w.writeback_valid = dirty_q[e];
              w.writeback_block = dirty_q[e] ? id : '0;
              dirty_q[e]        = 1'b0;
              expected_words.push_back(w);
              return;
            end
          end
          expected_words.push_back(w);
        end

        default: begin
          bad = (op == OP_WRITE) ? (off >= CACHE_BLOCK_BYTES) : (off > CACHE_BLOCK_BYTES);
          if (bad) begin
            w.offset_error = 1'b1;
            expected_words.push_back(w);
            return;
          end
          avail    = 32'(CACHE_BLOCK_BYTES) - 32'(off);
          w.length = LEN_W'((size < avail) ? size : avail);

          for (k = 0; k < CACHE_WAYS; k++) begin
            e = base + k;
            if (valid_q[e] && age_q[e] < AGE_MAX) age_q[e] = age_q[e] + 1'b1;
          end

          for (k = 0; k < CACHE_WAYS; k++) begin
            e = base + k;
            if (valid_q[e] && tag_q[e] == id) begin
              age_q[e] = '0;
              if (op == OP_WRITE) dirty_q[e] = 1'b1;
              w.hit = 1'b1;
              w.way = WAY_W'(k);
              expected_words.push_back(w);
              return;
            end
          end

          // first invalid way, else the oldest with ties to the higher way
          victim = 0;
          found  = 1'b0;
          for (k = 0; k < CACHE_WAYS && !found; k++) begin
            if (!valid_q[base + k]) begin
              victim = k;
              found  = 1'b1;
            end
          end
          if (!found) begin
            for (k = 0; k < CACHE_WAYS; k++) begin
              if (age_q[base + victim] <= age_q[base + k]) victim = k;
            end
          end

          e                 = base + victim;
          w.way             = WAY_W'(victim);
          w.writeback_valid = valid_q[e] && dirty_q[e];
          w.writeback_block = (valid_q[e] && dirty_q[e]) ? tag_q[e] : '0;
          w.fill_valid      = 1'b1;
          valid_q[e]        = 1'b1;
          dirty_q[e]        = (op == OP_WRITE);
          tag_q[e]          = id;
          age_q[e]          = '0;
          expected_words.push_back(w);
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    // Compare one returned word with the oldest prediction
    function void check_word(result_word_t got);
      result_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("result word returned with no access pending");
        mismatches++;
        return;
      end
      exp_w = expected_words.pop_front();
      cmp_field("hit",             exp_w.hit,             got.hit);
      cmp_field("set_index",       exp_w.set_index,       got.set_index);
      cmp_field("way",             exp_w.way,             got.way);
      cmp_field("length",          exp_w.length,          got.length);
      cmp_field("offset_error",    exp_w.offset_error,    got.offset_error);
      cmp_field("writeback_valid", exp_w.writeback_valid, got.writeback_valid);
      cmp_field("writeback_block", exp_w.writeback_block, got.writeback_block);
      cmp_field("fill_valid",      exp_w.fill_valid,      got.fill_valid);
      cmp_field("last",            exp_w.last,            got.last);
    endfunction
  endclass

endpackage

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the set-associative block cache controller. Drives directed
// corner accesses, then random traffic over a small block pool and a long run
// on one hot set that saturates ages and forces victim ties; every returned
// word is checked against the scoreboard's directory prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sacc_pkg::*;
  import cache_sb_pkg::*;

  localparam int STALL_LIMIT  = 4000;  // cycles with no word accepted on either side
  localparam int HOT_ACCESSES = 300;   // reads and writes on the hot set, > 255 to saturate
  localparam int RANDOM_ITEMS = 50;
  localparam int POOL_SIZE    = 32;
  localparam int DRAIN_CYCLES = 100;   // covers a full flush-all walk

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode    = '0;
  logic [ID_W-1:0]   block_id  = '0;
  logic [OFF_W-1:0]  offset    = '0;
  logic [SIZE_W-1:0] size      = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic [SET_W-1:0]  set_index;
  logic [WAY_W-1:0]  way;
  logic [LEN_W-1:0]  length;
  logic              offset_error;
  logic              writeback_valid;
  logic [ID_W-1:0]   writeback_block;
  logic              fill_valid;
  logic              last;

  dir_scoreboard     sb;
  result_word_t      seen_word;
  int                stall_cycles = 0;
  int                burst_left   = 1;
  rx_mode_e          rx_mode      = RX_STREAM;
  int                rx_left      = 0;
  logic [ID_W-1:0]   id_pool  [POOL_SIZE];
  logic [ID_W-1:0]   hot_tags [4];
  int                hot_set;
  int                hot_count;
  int                pick;

  set_assoc_block_cache_ctrl #(
    .SETS        (CACHE_SETS),
    .WAYS        (CACHE_WAYS),
    .BLOCK_BYTES (CACHE_BLOCK_BYTES)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .opcode_i          (opcode),
    .block_id_i        (block_id),
    .offset_i          (offset),
    .size_i            (size),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .hit_o             (hit),
    .set_index_o       (set_index),
    .way_o             (way),
    .length_o          (length),
    .offset_error_o    (offset_error),
    .writeback_valid_o (writeback_valid),
    .writeback_block_o (writeback_block),
    .fill_valid_o      (fill_valid),
    .last_o            (last)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Sample both channels at the rising edge. Check the result word before
  // noting a new access so a stray word cannot borrow a fresh prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_word = {hit, set_index, way, length, offset_error,
                     writeback_valid, writeback_block, fill_valid, last};
        sb.check_word(seen_word);
      end
      if (in_valid && in_ready) begin
        sb.note_access(op_e'(opcode), block_id, offset, size);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: pick a new random stall pattern whenever its countdown runs out;
  // streaming mode gives stretches with no backpressure at all.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM:   out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= ((rx_left % 4) == 0);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Drop valid and hold the sender until every predicted word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Gap between bursts: mostly short, sometimes long, now and then a full drain
  task automatic rest_sender();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) wait_drained();
    else if (r >= 35) idle_sender((r < 90) ? $urandom_range(1, 4) : $urandom_range(5, 20));
  endtask

  // Present one access word, hold it until accepted, then pace the burst
  task automatic send_word(op_e op, logic [ID_W-1:0] id, logic [OFF_W-1:0] off,
                           logic [SIZE_W-1:0] sz);
    @(negedge clk);
    in_valid <= 1'b1;
    opcode   <= op;
    block_id <= id;
    offset   <= off;
    size     <= sz;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      rest_sender();
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Mostly inside the block, with the boundary values and the far range mixed in
  function automatic logic [OFF_W-1:0] rand_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return OFF_W'($urandom_range(0, CACHE_BLOCK_BYTES - 1));
    if (r < 85) return OFF_W'(CACHE_BLOCK_BYTES);
    if (r < 90) return OFF_W'(CACHE_BLOCK_BYTES - 1);
    return OFF_W'($urandom());
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return SIZE_W'($urandom_range(0, 64));
    if (r < 60) return SIZE_W'($urandom_range(0, 1024));
    if (r < 70) return '0;
    if (r < 80) return '1;
    return $urandom();
  endfunction

  // Block id from the pool, fully random, or random but outside one set
  function automatic logic [ID_W-1:0] pick_id(int avoid_set);
    logic [ID_W-1:0] id;
    if (avoid_set >= 0) begin
      id = $urandom();
      id[SET_W-1:0] = SET_W'((avoid_set + $urandom_range(1, CACHE_SETS - 1)) % CACHE_SETS);
    end else if ($urandom_range(0, 4) == 0) begin
      id = $urandom();
    end else begin
      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return id;
  endfunction

  task automatic send_random_access(int avoid_set);
    int r;
    r = $urandom_range(0, 99);
    if (r < 42) send_word(OP_READ, pick_id(avoid_set), rand_offset(), rand_size());
    else if (r < 84) send_word(OP_WRITE, pick_id(avoid_set), rand_offset(), rand_size());
    else if (r < 94) send_word(OP_FLUSH, pick_id(avoid_set), OFF_W'($urandom()), $urandom());
    else send_word(OP_FLUSH_ALL, $urandom(), OFF_W'($urandom()), $urandom());
  endtask

  initial begin : main
    sb = new();
    // Cluster the pool on six sets so misses evict and hits recur
    foreach (id_pool[i]) begin
      id_pool[i] = ($urandom() & 32'hFFFF_FFF0) | 32'($urandom_range(0, 5));
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: range edges of offset and size, every opcode, hit and miss,
    // dirty eviction, flush of a dirty, clean and absent block, flush-all
    // with nothing dirty and with several dirty ways.
    send_word(OP_READ,      32'h0000_0000, 10'd0,   32'd0);
    send_word(OP_WRITE,     32'hFFFF_FFFF, 10'd511, 32'hFFFF_FFFF);
    send_word(OP_READ,      32'h0000_0000, 10'd512, 32'd100);   // read at block end is legal
    send_word(OP_WRITE,     32'h0000_0000, 10'd512, 32'd4);     // write at block end is not
    send_word(OP_READ,      32'h0000_0010, 10'h3FF, 32'd1);
    send_word(OP_WRITE,     32'h0000_0000, 10'd0,   32'd512);
    send_word(OP_WRITE,     32'h0000_0010, 10'd100, 32'd1000);
    send_word(OP_READ,      32'h0000_0020, 10'd0,   32'd511);
    send_word(OP_READ,      32'h0000_0030, 10'd1,   32'd600);
    send_word(OP_READ,      32'h0000_0040, 10'd7,   32'd3);     // full set: evict oldest, dirty
    send_word(OP_FLUSH,     32'h0000_0010, 10'h3FF, 32'hFFFF_FFFF);
    send_word(OP_FLUSH,     32'h0000_0010, 10'd0,   32'd0);
    send_word(OP_FLUSH,     32'h1234_5670, 10'd5,   32'd5);
    send_word(OP_FLUSH_ALL, 32'h0000_0000, 10'd0,   32'd0);
    send_word(OP_FLUSH_ALL, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    send_word(OP_WRITE,     32'hAAAA_AAAA, 10'h155, 32'h5555_5555);
    send_word(OP_WRITE,     32'h5555_5555, 10'h2AA, 32'hAAAA_AAAA);
    send_word(OP_WRITE,     32'h5555_5555, 10'h0AA, 32'hAAAA_AAAA);
    send_word(OP_READ,      32'hAAAA_AAAA, 10'd10,  32'd501);
    send_word(OP_WRITE,     32'h0000_0020, 10'd511, 32'd2);
    send_word(OP_FLUSH_ALL, 32'h0F0F_0F0F, 10'h2AA, 32'h0000_FFFF);
    wait_drained();

    // Random traffic over the pool
    repeat (RANDOM_ITEMS) send_random_access(-1);
    wait_drained();

    // Hot set: fill all four ways, then hammer only two of them so the
    // other two age to saturation and tie; noise stays out of this set.
    hot_set = $urandom_range(0, CACHE_SETS - 1);
    foreach (hot_tags[i]) begin
      hot_tags[i] = ($urandom() & 32'hFFFF_FFF0) | 32'(hot_set);
      send_word($urandom_range(0, 1) ? OP_WRITE : OP_READ, hot_tags[i],
                OFF_W'($urandom_range(0, CACHE_BLOCK_BYTES - 1)), rand_size());
    end
    hot_count = 0;
    while (hot_count < HOT_ACCESSES) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        send_word((pick < 44) ? OP_READ : OP_WRITE, hot_tags[pick % 2],
                  rand_offset(), rand_size());
        hot_count++;
      end else if (pick < 91) begin
        send_word(OP_FLUSH, hot_tags[$urandom_range(0, 3)], OFF_W'($urandom()), $urandom());
      end else begin
        send_random_access(hot_set);
      end
    end
    // New blocks into the hot set: evict the saturated pair, higher way first
    repeat (10) begin
      send_word($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                ($urandom() & 32'hFFFF_FFF0) | 32'(hot_set),
                OFF_W'($urandom_range(0, CACHE_BLOCK_BYTES - 1)), rand_size());
    end
    send_word(OP_FLUSH_ALL, $urandom(), OFF_W'($urandom()), $urandom());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $error("%0d predicted result words never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $error("no word accepted for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/sacc_pkg.sv
rtl/sacc_ram.sv
rtl/sacc_setmod.sv
rtl/sacc_dpath.sv
rtl/sacc_ctrl.sv
rtl/set_assoc_block_cache_ctrl.sv
tb/sv/cache_sb_pkg.sv
tb/sv/tb.sv
